### rtl/gsc_pkg.sv
package gsc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int DEGREE_BITS  = 8;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DEG_W = DEGREE_BITS;

  // large enough for the k largest degrees and for n*(n-1)
  localparam int LEFT_MAX = MAX_VERTICES * ((1 << DEGREE_BITS) - 1);
  localparam int RIGHT_MAX = MAX_VERTICES * (MAX_VERTICES - 1);
  localparam int SUM_MAX = (LEFT_MAX > RIGHT_MAX) ? LEFT_MAX : RIGHT_MAX;
  localparam int SUM_W = $clog2(SUM_MAX + 1);

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_ODD      = 2'd1,
    VERDICT_FAIL     = 2'd2,
    VERDICT_OVERFLOW = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [CNT_W-1:0]   fail_pos;
    logic [CNT_W-1:0]   count;
  } gsc_result_t;

  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [DEG_W-1:0]   wr_data;
    logic [IDX_W-1:0]   rd_addr;
  } gsc_mem_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]   cmp_a;
    logic [SUM_W-1:0]   cmp_b;
    logic [SUM_W-1:0]   add_a;
    logic [SUM_W-1:0]   add_b;
  } gsc_alu_req_t;

endpackage

### rtl/gsc_mem.sv
module gsc_mem import gsc_pkg::*; (
  input  logic               clk,
  input  gsc_mem_req_t       req,
  output logic [DEG_W-1:0]   rd_data
);

  logic [DEG_W-1:0] mem [MAX_VERTICES];
  logic [DEG_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/gsc_alu.sv
module gsc_alu import gsc_pkg::*; (
  input  gsc_alu_req_t       req,
  output logic               gt,
  output logic [SUM_W-1:0]   sum
);

  assign gt  = req.cmp_a > req.cmp_b;
  assign sum = req.add_a + req.add_b;

endmodule

### rtl/gsc_engine.sv
module gsc_engine import gsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [CNT_W-1:0]   n,
  input  logic [DEG_W-1:0]   rd_data,
  output gsc_mem_req_t       mem_req,
  output logic               busy,
  output logic               done,
  output gsc_result_t        result
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SCAN    = 7'b0000010,
    ST_SWAP_HI = 7'b0000100,
    ST_SWAP_LO = 7'b0001000,
    ST_KINIT   = 7'b0010000,
    ST_KSCAN   = 7'b0100000,
    ST_KCMP    = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_pos_r, pend_pos_nxt;
  logic [DEG_W-1:0]   max_r, max_nxt;
  logic [IDX_W-1:0]   max_pos_r, max_pos_nxt;
  logic [DEG_W-1:0]   old_r, old_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [SUM_W-1:0]   left_r, left_nxt;
  logic [SUM_W-1:0]   right_r, right_nxt;

  gsc_alu_req_t       alu_req;
  logic               alu_gt;
  logic [SUM_W-1:0]   alu_sum;

  logic [CNT_W-1:0]   n_m1;
  logic [CNT_W-1:0]   k_m1;
  logic [2*CNT_W-1:0] kk;
  logic               issue;
  logic               last_pend;
  logic               left_hit;
  logic [SUM_W-1:0]   capped;

  gsc_alu u_alu (
    .req (alu_req),
    .gt  (alu_gt),
    .sum (alu_sum)
  );

  assign n_m1      = n_r - CNT_W'(1);
  assign k_m1      = k_r - CNT_W'(1);
  assign kk        = k_r * k_m1;
  assign issue     = ((state_r == ST_SCAN) || (state_r == ST_KSCAN)) && (j_r < n_r);
  assign last_pend = pend_r && (pend_pos_r == n_m1[IDX_W-1:0]);
  assign left_hit  = pend_pos_r == k_m1[IDX_W-1:0];
  // min(d, k) for the degrees past position k
  assign capped    = alu_gt ? SUM_W'(k_r) : SUM_W'(rd_data);

  always_comb begin
    alu_req = '0;
    case (state_r)
      ST_SCAN: begin
        alu_req.cmp_a = SUM_W'(rd_data);
        alu_req.cmp_b = SUM_W'(max_r);
      end
      ST_KSCAN: begin
        alu_req.cmp_a = SUM_W'(rd_data);
        alu_req.cmp_b = SUM_W'(k_r);
        alu_req.add_a = left_hit ? left_r : right_r;
        alu_req.add_b = left_hit ? SUM_W'(rd_data) : capped;
      end
      ST_KCMP: begin
        alu_req.cmp_a = left_r;
        alu_req.cmp_b = right_r;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    i_nxt           = i_r;
    j_nxt           = issue ? j_r + CNT_W'(1) : j_r;
    pend_nxt        = issue;
    pend_pos_nxt    = j_r[IDX_W-1:0];
    max_nxt         = max_r;
    max_pos_nxt     = max_pos_r;
    old_nxt         = old_r;
    k_nxt           = k_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    mem_req         = '0;
    mem_req.rd_addr = j_r[IDX_W-1:0];
    done            = 1'b0;
    result.verdict  = VERDICT_OK;
    result.fail_pos = '0;
    result.count    = n_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt    = n;
          i_nxt    = '0;
          j_nxt    = '0;
          pend_nxt = 1'b0;
          k_nxt    = CNT_W'(1);
          left_nxt = '0;
          state_nxt = (n == CNT_W'(1)) ? ST_KINIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          if (pend_pos_r == i_r) begin
            max_nxt     = rd_data;
            max_pos_nxt = pend_pos_r;
            old_nxt     = rd_data;
          end else if (alu_gt) begin
            max_nxt     = rd_data;
            max_pos_nxt = pend_pos_r;
          end
        end
        if (last_pend) begin
          state_nxt = ST_SWAP_HI;
        end
      end
      ST_SWAP_HI: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = i_r;
        mem_req.wr_data = max_r;
        state_nxt       = ST_SWAP_LO;
      end
      ST_SWAP_LO: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = max_pos_r;
        mem_req.wr_data = old_r;
        if (CNT_W'(i_r) + CNT_W'(2) == n_r) begin
          j_nxt     = '0;
          k_nxt     = CNT_W'(1);
          left_nxt  = '0;
          state_nxt = ST_KINIT;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          j_nxt     = CNT_W'(i_r) + CNT_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_KINIT: begin
        right_nxt = SUM_W'(kk);
        state_nxt = ST_KSCAN;
      end
      ST_KSCAN: begin
        if (pend_r) begin
          if (left_hit) begin
            left_nxt = alu_sum;
          end else begin
            right_nxt = alu_sum;
          end
        end
        if (last_pend) begin
          state_nxt = ST_KCMP;
        end
      end
      ST_KCMP: begin
        if (alu_gt) begin
          done            = 1'b1;
          result.verdict  = VERDICT_FAIL;
          result.fail_pos = k_r;
          state_nxt       = ST_IDLE;
        end else if (k_r == n_r) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          j_nxt     = k_r;
          state_nxt = ST_KINIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pend_pos_r <= pend_pos_nxt;
    max_r      <= max_nxt;
    max_pos_r  <= max_pos_nxt;
    old_r      <= old_nxt;
    k_r        <= k_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
  end

  assign busy = state_r != ST_IDLE;

endmodule

### rtl/graphical_sequence_check.sv
// an item that is not last is stored, unless past MAX_VERTICES; a last item whose verdict is
// too many degrees or an odd sum gives its result on the next cycle
// otherwise a selection sort and the per-k test run on one shared compare/add unit over
// the degree memory (one write port, one read port), with the input stalled meanwhile
// reset (synchronous, active low) clears the counters, flags and sequencer; the degree memory
// is not cleared since only written entries are ever read
module graphical_sequence_check import gsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_degree,
  input  logic               in_last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_verdict,
  output logic [CNT_W-1:0]   out_failing_position,
  output logic [CNT_W-1:0]   out_vertex_count
);

  logic [CNT_W-1:0]   count_r;
  logic               odd_r;
  logic               ovf_r;
  logic               out_valid_r;
  gsc_result_t        out_res_r;

  logic               accept;
  logic [DEG_W-1:0]   deg;
  logic               stored;
  logic [CNT_W-1:0]   count_new;
  logic               odd_new;
  logic               ovf_new;
  logic               imm_done;
  gsc_result_t        imm_res;
  logic               eng_start;

  gsc_mem_req_t       eng_req;
  gsc_mem_req_t       mem_req;
  logic [DEG_W-1:0]   rd_data;
  logic               eng_busy;
  logic               eng_done;
  gsc_result_t        eng_res;

  assign in_stall  = eng_busy | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign deg       = in_degree[DEG_W-1:0];
  assign stored    = count_r < CNT_W'(MAX_VERTICES);
  assign count_new = stored ? count_r + CNT_W'(1) : count_r;
  assign odd_new   = odd_r ^ (stored & deg[0]);
  assign ovf_new   = ovf_r | ~stored;

  assign imm_done  = accept & in_last_item & (ovf_new | odd_new);
  assign eng_start = accept & in_last_item & ~ovf_new & ~odd_new;

  always_comb begin
    imm_res.verdict  = ovf_new ? VERDICT_OVERFLOW : VERDICT_ODD;
    imm_res.fail_pos = '0;
    imm_res.count    = count_new;
  end

  // engine owns the memory while it runs, loads write otherwise
  always_comb begin
    mem_req = eng_req;
    if (!eng_busy) begin
      mem_req.wr_en   = accept & stored;
      mem_req.wr_addr = count_r[IDX_W-1:0];
      mem_req.wr_data = deg;
    end
  end

  gsc_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  gsc_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (eng_start),
    .n       (count_new),
    .rd_data (rd_data),
    .mem_req (eng_req),
    .busy    (eng_busy),
    .done    (eng_done),
    .result  (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      odd_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last_item) begin
          count_r <= '0;
          odd_r   <= 1'b0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= count_new;
          odd_r   <= odd_new;
          ovf_r   <= ovf_new;
        end
      end
      if (imm_done || eng_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (imm_done) begin
      out_res_r <= imm_res;
    end else if (eng_done) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = out_res_r.verdict;
  assign out_failing_position = out_res_r.fail_pos;
  assign out_vertex_count     = out_res_r.count;

  // the engine only finishes into an empty output register
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    eng_done |-> !out_valid_r)
    else $error("engine result would overwrite a pending result");

  // a sequence never starts while the engine still works on the previous one
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    eng_start |-> !eng_busy && !eng_done)
    else $error("engine started while busy");

  a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.verdict == VERDICT_FAIL) |->
      (out_res_r.fail_pos != '0) && (out_res_r.fail_pos <= out_res_r.count))
    else $error("failing position out of range");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.verdict != VERDICT_FAIL) |-> out_res_r.fail_pos == '0)
    else $error("failing position set without a failing verdict");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gsc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX  = 10;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_degree = '0;
  logic             in_last_item = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_verdict;
  logic [CNT_W-1:0] out_failing_position;
  logic [CNT_W-1:0] out_vertex_count;

  // verdicts predicted for sequences already closed, oldest first
  gsc_result_t      pending_verdicts[$];
  // sequence being collected
  logic [DEG_W-1:0] seq_degrees[$];
  int unsigned      seq_total = 0;
  bit               seq_overflow = 1'b0;

  int mismatch_count = 0;
  int checked_count = 0;
  int degrees_sent = 0;
  int sequences_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int verdict_seen[4] = '{0, 0, 0, 0};
  int stall_mode = 0;

  always #6 clk = ~clk;

  graphical_sequence_check u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_degree            (in_degree),
    .in_last_item         (in_last_item),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_verdict          (out_verdict),
    .out_failing_position (out_failing_position),
    .out_vertex_count     (out_vertex_count)
  );

  // overflow, odd-sum or erdos-gallai verdict for one closed sequence
  function automatic gsc_result_t predict_verdict(input logic [DEG_W-1:0] degs[$],
                                                  input bit overflow,
                                                  input int unsigned total);
    gsc_result_t r;
    int          d[$];
    int          left;
    int          right;
    r.verdict  = VERDICT_OK;
    r.fail_pos = '0;
    r.count    = CNT_W'(degs.size());
    if (overflow) begin
      r.verdict = VERDICT_OVERFLOW;
    end else if (total % 2 != 0) begin
      r.verdict = VERDICT_ODD;
    end else begin
      foreach (degs[i]) d.push_back(int'(degs[i]));
      d.rsort();
      for (int k = 1; k <= d.size(); k++) begin
        left  = 0;
        right = k * (k - 1);
        for (int i = 0; i < d.size(); i++) begin
          if (i < k) left += d[i];
          else right += (d[i] < k) ? d[i] : k;
        end
        if (left > right) begin
          r.verdict  = VERDICT_FAIL;
          r.fail_pos = CNT_W'(k);
          break;
        end
      end
    end
    return r;
  endfunction

  // degrees of a random simple graph, p = edge probability in percent
  function automatic void make_graph(input int n, input int p, output int deg[$]);
    deg.delete();
    repeat (n) deg.push_back(0);
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if ($urandom_range(0, 99) < p) begin
          deg[i]++;
          deg[j]++;
        end
      end
    end
  endfunction

  // one request, with burst/gap idling in front of it
  task automatic send_degree(input logic [7:0] d, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_degree    <= d;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    degrees_sent++;
    if (seq_degrees.size() < MAX_VERTICES) begin
      seq_degrees.push_back(d[DEG_W-1:0]);
      seq_total += d[DEG_W-1:0];
    end else begin
      seq_overflow = 1'b1;
    end
    if (last) begin
      pending_verdicts.push_back(predict_verdict(seq_degrees, seq_overflow, seq_total));
      seq_degrees.delete();
      seq_total    = 0;
      seq_overflow = 1'b0;
      sequences_sent++;
    end
  endtask

  task automatic send_sequence(input int degs[$]);
    foreach (degs[i]) send_degree(8'(degs[i]), i == degs.size() - 1);
  endtask

  task automatic test_directed_cases;
    send_degree(8'd0, 1'b1);
    send_degree(8'd255, 1'b1);
    send_degree(8'd254, 1'b1);
    send_degree(8'd1, 1'b0);
    send_degree(8'd1, 1'b1);
    repeat (2) send_degree(8'd2, 1'b0);
    send_degree(8'd2, 1'b1);
    repeat (3) send_degree(8'd3, 1'b0);
    send_degree(8'd3, 1'b1);
    // unsorted input with an isolated vertex
    send_degree(8'd1, 1'b0);
    send_degree(8'd0, 1'b0);
    send_degree(8'd1, 1'b1);
    // star
    send_degree(8'd4, 1'b0);
    repeat (3) send_degree(8'd1, 1'b0);
    send_degree(8'd1, 1'b1);
    // even sums that break the inequality
    send_degree(8'd2, 1'b0);
    send_degree(8'd2, 1'b1);
    send_degree(8'd128, 1'b0);
    send_degree(8'd0, 1'b1);
  endtask

  task automatic test_random_graphs(input int item_budget);
    int deg[$];
    int n;
    int sent;
    sent = 0;
    while (sent < item_budget) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      make_graph(n, $urandom_range(0, 100), deg);
      send_sequence(deg);
      sent += n;
    end
  endtask

  task automatic test_broken_sequences(input int item_budget);
    int deg[$];
    int n;
    int idx;
    int sent;
    sent = 0;
    while (sent < item_budget) begin
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      idx = $urandom_range(0, n - 1);
      case ($urandom_range(0, 3))
        0: begin
          // parity kept, degree moved by two
          make_graph(n, $urandom_range(0, 100), deg);
          if (deg[idx] >= 2 && $urandom_range(0, 1) == 1) deg[idx] -= 2;
          else deg[idx] += 2;
        end
        1: begin
          make_graph(n, $urandom_range(0, 100), deg);
          deg[idx] += 1;
        end
        2: begin
          deg.delete();
          repeat (n) deg.push_back($urandom_range(0, n));
        end
        default: begin
          deg.delete();
          repeat (n) deg.push_back($urandom_range(0, 255));
        end
      endcase
      send_sequence(deg);
      sent += n;
    end
  endtask

  task automatic test_long_sequences;
    int deg[$];
    make_graph(MAX_VERTICES, 100, deg);
    send_sequence(deg);
    make_graph(MAX_VERTICES, $urandom_range(5, 95), deg);
    send_sequence(deg);
    deg.delete();
    repeat (MAX_VERTICES) deg.push_back($urandom_range(0, 255));
    send_sequence(deg);
    // too many degrees, the surplus is dropped
    repeat (3) begin
      make_graph(MAX_VERTICES, $urandom_range(0, 100), deg);
      repeat ($urandom_range(1, 6)) deg.push_back($urandom_range(0, 255));
      send_sequence(deg);
    end
  endtask

  always @(posedge clk) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_count % 7) < 3;
    endcase
  end

  always @(posedge clk) begin : check_results
    gsc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("mismatch: unexpected verdict %0d pos %0d count %0d", out_verdict,
                   out_failing_position, out_vertex_count);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        checked_count++;
        verdict_seen[want.verdict]++;
        if (out_verdict !== want.verdict || out_failing_position !== want.fail_pos ||
            out_vertex_count !== want.count) begin
          if (mismatch_count < REPORT_MAX)
            $display("mismatch: verdict %0d/%0d pos %0d/%0d count %0d/%0d (exp/act)",
                     want.verdict, out_verdict, want.fail_pos, out_failing_position,
                     want.count, out_vertex_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_graphs(700);
    test_broken_sequences(430);
    test_long_sequences();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("tb_top: %0d degree requests in %0d sequences, %0d verdicts checked",
             degrees_sent, sequences_sent, checked_count);
    $display("tb_top: graphical %0d, odd sum %0d, inequality %0d, overflow %0d, mismatches %0d",
             verdict_seen[VERDICT_OK], verdict_seen[VERDICT_ODD], verdict_seen[VERDICT_FAIL],
             verdict_seen[VERDICT_OVERFLOW], mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/gsc_pkg.sv
rtl/gsc_mem.sv
rtl/gsc_alu.sv
rtl/gsc_engine.sv
rtl/graphical_sequence_check.sv
tb/tb_top.sv
